[design/u2da_pkg.sv]
// shared types, constants and helpers for the decimal ascii converter
package u2da_pkg;

  // fixed field widths
  localparam int IN_WIDTH = 32;
  localparam int CHAR_WIDTH = 6;
  localparam int DIGIT_WIDTH = 4;

  // default width of the converted number
  localparam int VALUE_WIDTH_DEF = 32;

  // ascii code of '0' within the character field
  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;

  typedef logic [DIGIT_WIDTH-1:0] digit_t;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic clr;
    logic conv;
    logic dshift;
  } cell_ctrl_t;

  // decimal digits needed for the largest w-bit number: floor(w*log10(2)) + 1
  function automatic int dec_digits(input int w);
    int d;
    d = ((w * 1233) >>> 12) + 1;
    return d;
  endfunction

endpackage

[design/u2da_cell.sv]
// one bcd digit cell: add-3 adjust and shift during conversion, digit shift on output
module u2da_cell (
  input  logic                 clk,
  input  u2da_pkg::cell_ctrl_t ctrl,
  input  logic                 bit_in,
  input  u2da_pkg::digit_t     digit_in,
  output logic                 bit_out,
  output u2da_pkg::digit_t     digit_q
);

  u2da_pkg::digit_t digit_r;
  u2da_pkg::digit_t digit_nxt;
  u2da_pkg::digit_t adj;

  // add 3 when the digit would overflow past 9 after doubling
  always_comb begin
    if (digit_r >= u2da_pkg::DIGIT_WIDTH'(5)) begin
      adj = digit_r + u2da_pkg::DIGIT_WIDTH'(3);
    end else begin
      adj = digit_r;
    end
  end

  assign bit_out = adj[u2da_pkg::DIGIT_WIDTH-1];
  assign digit_q = digit_r;

  // next digit value
  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clr) begin
      digit_nxt = '0;
    end else if (ctrl.conv) begin
      digit_nxt = {adj[u2da_pkg::DIGIT_WIDTH-2:0], bit_in};
    end else if (ctrl.dshift) begin
      digit_nxt = digit_in;
    end
  end

  // digit storage
  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

[design/unsigned_to_decimal_ascii.sv]
// Top level: unsigned binary to decimal ascii, one beat per character, msd first.
// Conversion shifts the value bit by bit through a chain of bcd cells, one cell per decimal digit.
// Output then walks the cells from the top, skipping leading zeros and waiting on out_stall.
// in_stall stays high until the last character is emitted, so no new number is taken before.
// Synchronous active-low reset returns to idle with no pending output beat.
module unsigned_to_decimal_ascii #(
  parameter int VALUE_WIDTH = u2da_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [u2da_pkg::IN_WIDTH-1:0]   in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [u2da_pkg::CHAR_WIDTH-1:0] out_digit_char,
  output logic                            out_last
);

  localparam int ND = u2da_pkg::dec_digits(VALUE_WIDTH);
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int REM_W = $clog2(ND + 1);
  localparam int LOAD_W = (VALUE_WIDTH < u2da_pkg::IN_WIDTH) ? VALUE_WIDTH
                                                             : u2da_pkg::IN_WIDTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                      state_r, state_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic [REM_W-1:0]                rem_r, rem_nxt;
  logic                            started_r, started_nxt;
  logic [VALUE_WIDTH-1:0]          bin_r, bin_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [u2da_pkg::CHAR_WIDTH-1:0] out_digit_r, out_digit_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            slot_free;
  u2da_pkg::cell_ctrl_t            ctrl;
  u2da_pkg::digit_t                top_digit;

  logic                            cell_bit_in  [ND];
  logic                            cell_bit_out [ND];
  u2da_pkg::digit_t                cell_dig_in  [ND];
  u2da_pkg::digit_t                cell_dig_q   [ND];

  // chain of bcd cells, cell 0 is the least significant digit
  for (genvar i = 0; i < ND; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_bit_in[i] = bin_r[VALUE_WIDTH-1];
      assign cell_dig_in[i] = '0;
    end else begin : g_rest
      assign cell_bit_in[i] = cell_bit_out[i-1];
      assign cell_dig_in[i] = cell_dig_q[i-1];
    end
    u2da_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bit_in   (cell_bit_in[i]),
      .digit_in (cell_dig_in[i]),
      .bit_out  (cell_bit_out[i]),
      .digit_q  (cell_dig_q[i])
    );
  end

  assign top_digit = cell_dig_q[ND-1];
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);

  // sequencer: load, convert, then walk digits out of the top cell
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    started_nxt   = started_r;
    bin_nxt       = bin_r;
    out_valid_nxt = out_valid_r;
    out_digit_nxt = out_digit_r;
    out_last_nxt  = out_last_r;
    ctrl          = '0;

    // output beat taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          bin_nxt   = VALUE_WIDTH'(in_value[LOAD_W-1:0]);
          ctrl.clr  = 1'b1;
          cnt_nxt   = CNT_W'(VALUE_WIDTH);
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.conv = 1'b1;
        bin_nxt   = bin_r << 1;
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          rem_nxt     = REM_W'(ND);
          started_nxt = 1'b0;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!started_r && (top_digit == '0) && (rem_r != REM_W'(1))) begin
          // leading zero, drop it
          ctrl.dshift = 1'b1;
          rem_nxt     = rem_r - REM_W'(1);
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_digit_nxt = u2da_pkg::ASCII_ZERO
                        + u2da_pkg::CHAR_WIDTH'(top_digit);
          out_last_nxt  = (rem_r == REM_W'(1));
          ctrl.dshift   = 1'b1;
          rem_nxt       = rem_r - REM_W'(1);
          started_nxt   = 1'b1;
          if (rem_r == REM_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bin_r       <= bin_nxt;
    out_digit_r <= out_digit_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_digit_r;
  assign out_last       = out_last_r;

endmodule

[design/u2da_checker.sv]
// port-level checks for the decimal ascii converter, bound to the top level
module u2da_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [u2da_pkg::CHAR_WIDTH-1:0] out_digit_char,
  input logic                            out_last
);

  // after reset the block is idle with no beat pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("not idle after reset");

  // a stalled output beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_digit_char) && $stable(out_last)))
    else $error("stalled output beat changed");

  // every character is a decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_digit_char >= 6'd48) && (out_digit_char <= 6'd57)))
    else $error("character outside '0'..'9'");

  // conversion keeps the input side busy after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall ##1 in_stall))
    else $error("input taken again during conversion");

endmodule

bind unsigned_to_decimal_ascii u2da_checker u_u2da_checker (.*);

[test/unsigned_to_decimal_ascii_test.sv]
// self-checking testbench for the unsigned to decimal ascii converter
`timescale 1ns / 1ps

module unsigned_to_decimal_ascii_test;

  localparam int VALUE_WIDTH = u2da_pkg::VALUE_WIDTH_DEF;
  localparam int MAX_DIGITS = 20;
  localparam int END_CYCLES = 100;

  // one character beat of a converted number
  typedef struct {
    logic [u2da_pkg::CHAR_WIDTH-1:0] digit_char;
    logic                            last;
  } decimal_char_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [u2da_pkg::IN_WIDTH-1:0]   in_value = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [u2da_pkg::CHAR_WIDTH-1:0] out_digit_char;
  logic                            out_last;

  logic [u2da_pkg::IN_WIDTH-1:0] pending_values[$];
  decimal_char_t                 expected_chars[$];

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int numbers_accepted = 0;
  int chars_checked = 0;
  int fail_count = 0;
  int length_seen[1:MAX_DIGITS];

  unsigned_to_decimal_ascii #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_digit_char(out_digit_char),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  // decimal digits of the masked value, most significant first, onto the expected queue
  function automatic void queue_decimal_text(input logic [u2da_pkg::IN_WIDTH-1:0] value);
    longint unsigned v;
    longint unsigned mask;
    logic [u2da_pkg::DIGIT_WIDTH-1:0] rev_digits[MAX_DIGITS];
    int n;
    decimal_char_t c;
    mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
    v = 64'(value) & mask;
    n = 0;
    if (v == 0) begin
      rev_digits[0] = '0;
      n = 1;
    end
    while (v != 0 && n < MAX_DIGITS) begin
      rev_digits[n] = u2da_pkg::DIGIT_WIDTH'(v % 10);
      v = v / 10;
      n++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      c.digit_char = u2da_pkg::ASCII_ZERO + u2da_pkg::CHAR_WIDTH'(rev_digits[k]);
      c.last = (k == 0);
      expected_chars.push_back(c);
    end
    length_seen[n]++;
  endfunction

  // random number, spread over all decimal lengths and over all bit patterns
  function automatic logic [u2da_pkg::IN_WIDTH-1:0] pick_value();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned r;
    int n;
    int mode;
    mode = $urandom_range(9);
    if (mode <= 3) begin
      n = $urandom_range(10, 1);
      lo = 1;
      for (int i = 1; i < n; i++) lo = lo * 10;
      hi = lo * 10 - 1;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      r = {$urandom, $urandom};
      return u2da_pkg::IN_WIDTH'(lo + r % (hi - lo + 1));
    end else if (mode <= 6) begin
      return $urandom;
    end else if (mode <= 8) begin
      return $urandom >> $urandom_range(31);
    end else begin
      case ($urandom_range(2))
        0: return '0;
        1: return '1;
        default: return 32'd1_000_000_000 - $urandom_range(1);
      endcase
    end
  endfunction

  // sender: one number per beat, idling at the phase's rate
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        queue_decimal_text(in_value);
        numbers_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_values.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_value <= pending_values.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each character beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected beat: actual char %0d last %0b",
                   $time, out_digit_char, out_last);
          fail_count++;
        end else begin
          decimal_char_t want;
          want = expected_chars.pop_front();
          if (out_digit_char !== want.digit_char) begin
            $display("%0t: digit_char mismatch: expected %0d actual %0d",
                     $time, want.digit_char, out_digit_char);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last mismatch: expected %0b actual %0b",
                     $time, want.last, out_last);
            fail_count++;
          end
          chars_checked++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // hold off until everything queued has been sent and every character has come back
  task automatic drain_all();
    while (pending_values.size() != 0 || in_valid || expected_chars.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    logic [u2da_pkg::IN_WIDTH-1:0] directed_vals[];
    int sender_pcts[4];
    int recv_pcts[4];
    int lengths_hit;

    directed_vals = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
      32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999, 32'd1000000,
      32'd9999999, 32'd10000000, 32'd99999999, 32'd100000000,
      32'd999999999, 32'd1000000000, 32'd4294967295, 32'd4294967294,
      32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
    };
    sender_pcts = '{0, 75, 0, 38};
    recv_pcts = '{0, 0, 75, 38};

    foreach (length_seen[i]) length_seen[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed numbers: zero, every decimal length boundary, extremes of the field
    foreach (directed_vals[i]) pending_values.push_back(directed_vals[i]);
    drain_all();

    // random phases, each followed by a full drain before the next one starts
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = sender_pcts[p];
      recv_stall_pct = recv_pcts[p];
      repeat (37) pending_values.push_back(pick_value());
      drain_all();
    end

    sender_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (END_CYCLES) @(posedge clk);

    lengths_hit = 0;
    for (int i = 1; i <= 10; i++) if (length_seen[i] > 0) lengths_hit++;
    $display("run covered %0d numbers and %0d character beats, %0d of 10 decimal lengths",
             numbers_accepted, chars_checked, lengths_hit);
    $display("  with sender idling, receiver stalling, both, and drained pauses between phases");
    if (fail_count == 0) begin
      $display("** unsigned_to_decimal_ascii: PASSED **");
    end else begin
      $display("** unsigned_to_decimal_ascii: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d characters still expected", expected_chars.size());
    $display("** unsigned_to_decimal_ascii: FAILED **");
    $finish;
  end

endmodule

[sim.f]
design/u2da_pkg.sv
design/u2da_cell.sv
design/unsigned_to_decimal_ascii.sv
design/u2da_checker.sv
test/unsigned_to_decimal_ascii_test.sv
